### rtl/spbg_pkg.sv
// ----------------------------------------------------------------------------
// Sine ping burst generator package
// Register indexes, reset values, fixed formats and the quarter-wave sine
// polynomial that builds the lookup table at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package spbg_pkg;

   // Register indexes of the configuration port
   localparam int unsigned CSR_INDEX_W = 2;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_STEP  = 2'd0,
      CSR_HALF_LENGTH = 2'd1,
      CSR_AMP_STEP    = 2'd2
   } csr_index_type;

   localparam int unsigned CSR_DATA_W   = 32;
   localparam int unsigned PHASE_W      = 32;
   localparam int unsigned HALF_W       = 11;
   localparam int unsigned ENV_W        = 28;
   localparam int unsigned SAMPLE_W     = 13;
   localparam int unsigned SINE_W       = 17;
   localparam int unsigned MAG_W        = 14;

   localparam logic [PHASE_W-1:0] PHASE_STEP_RESET  = 32'd944892805;
   localparam logic [HALF_W-1:0]  HALF_LENGTH_RESET = 11'd80;
   localparam logic [ENV_W-1:0]   AMP_STEP_RESET    = 28'd2457600;

   // Envelope peak of 3000.0 in Q12.16 and the output limit
   localparam logic [ENV_W-1:0]   ENV_PEAK     = 28'd196608000;
   localparam logic [MAG_W-1:0]   SAMPLE_LIMIT = 14'd3000;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // sin(x) in Q30 for x in Q30 radians, 9th-order odd polynomial in Horner
   // form with truncating steps. Only evaluated at elaboration.
   function automatic logic [63:0] sin_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      return (x * t) >> 30;
   endfunction

endpackage

`default_nettype wire

### rtl/spbg_sine_rom.sv
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Constant table of DEPTH+1 unsigned Q16 entries, sin(i*pi/(2*DEPTH)).
// ----------------------------------------------------------------------------
`default_nettype none

module spbg_sine_rom #(
   parameter int unsigned DEPTH = 256
) (
   input  wire logic [$clog2(DEPTH+1)-1:0] rom_index,
   output logic      [spbg_pkg::SINE_W-1:0] rom_value
);
   import spbg_pkg::*;

   logic [SINE_W-1:0] rom_word [0:DEPTH];

   for (genvar i = 0; i <= DEPTH; i++) begin : g_entry
      localparam logic [63:0] ANGLE = (HALF_PI_Q30 * 64'(i)) / DEPTH;
      localparam logic [63:0] ENTRY = (sin_q30(ANGLE) + 64'd8192) >> 14;
      assign rom_word[i] = ENTRY[SINE_W-1:0];
   end

   assign rom_value = rom_word[rom_index];

endmodule

`default_nettype wire

### rtl/sine_ping_burst_generator_top.sv
// ----------------------------------------------------------------------------
// Sine ping burst generator
// Tone burst with a triangular envelope, one PCM sample per request.
// ----------------------------------------------------------------------------
// Each request yields exactly one response sample. The block takes one
// request per clock cycle unless a stalled response holds the lookup stage.
// A request is captured in the lookup stage when it is accepted, and its
// sample is loaded into the response register once that register is empty
// or being drained. The rate is set by the phase and envelope
// accumulators, which close in a single add per cycle. The sine
// lookup and the envelope multiply run in a two-register pipeline behind
// them. A request with new_frame set restarts the burst at phase and envelope
// zero. A frame holds twice the half length in samples; the final one is
// flagged, and the following request starts a fresh burst on its own.
// Configuration writes are accepted in every cycle outside reset and must be
// made only while no request is in flight.
`default_nettype none

module sine_ping_burst_generator_top #(
   parameter int unsigned SINE_TABLE_DEPTH = 256,
   parameter int unsigned MAX_HALF_LENGTH  = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request channel
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_new_frame,
   // Response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [spbg_pkg::SAMPLE_W-1:0]    rsp_sample,
   output logic                                    rsp_last_of_frame,
   // Configuration write channel
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [spbg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [spbg_pkg::CSR_DATA_W-1:0]    csr_data
);
   import spbg_pkg::*;

   // Width of the table index; it must hold DEPTH itself for the second and
   // fourth quadrants, which read the table backwards from DEPTH.
   localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int unsigned PROD_W = 30 + IDX_W;
   // The position runs up to twice the largest half length minus one.
   localparam int unsigned POS_W  = $clog2(2 * MAX_HALF_LENGTH);
   localparam int unsigned LIM_W  = (POS_W > HALF_W) ? POS_W : HALF_W;
   localparam logic [IDX_W-1:0] DEPTH_V = IDX_W'(SINE_TABLE_DEPTH);
   localparam logic [LIM_W-1:0] MAX_H   = LIM_W'(MAX_HALF_LENGTH);

   // Configuration registers
   logic [PHASE_W-1:0] phase_step_ff;
   logic [HALF_W-1:0]  half_length_ff;
   logic [ENV_W-1:0]   amp_step_ff;

   // Burst state
   logic [PHASE_W-1:0] phase_ff,    phase_in;
   logic [ENV_W-1:0]   envelope_ff, envelope_in;
   logic [POS_W-1:0]   position_ff, position_in;

   // Lookup stage
   logic               a_valid_ff, a_valid_in;
   logic [1:0]         a_quad_ff;
   logic [IDX_W-1:0]   a_idx_ff;
   logic [ENV_W-1:0]   a_env_ff;
   logic               a_last_ff;

   // Response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_last_ff;

   logic req_accept;
   logic out_load;

   // ------------------------------------------------------------------------
   // Handshakes. The lookup stage moves on whenever the response register is
   // empty or being drained, so a new request can enter while a finished
   // sample is still waiting on the response side.
   // ------------------------------------------------------------------------
   assign out_load   = a_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !reset && (!a_valid_ff || out_load);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = !reset;

   // ------------------------------------------------------------------------
   // Configuration writes. Writes to an index past the list are dropped.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= PHASE_STEP_RESET;
         half_length_ff <= HALF_LENGTH_RESET;
         amp_step_ff    <= AMP_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PHASE_STEP:  phase_step_ff  <= csr_data[PHASE_W-1:0];
            CSR_HALF_LENGTH: half_length_ff <= csr_data[HALF_W-1:0];
            CSR_AMP_STEP:    amp_step_ff    <= csr_data[ENV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Burst sequencing for the request being accepted.
   // ------------------------------------------------------------------------
   logic [PHASE_W-1:0] phase_cur;
   logic [ENV_W-1:0]   env_cur;
   logic [POS_W-1:0]   pos_cur;
   logic [LIM_W-1:0]   half_ext;
   logic [LIM_W-1:0]   half_lim;
   logic [POS_W-1:0]   half_eff;
   logic [POS_W:0]     twice_half;
   logic [POS_W-1:0]   last_pos;
   logic               is_last;
   logic [ENV_W:0]     env_up;
   logic [PROD_W-1:0]  idx_prod;

   always_comb begin
      // A new frame clears the state before this sample is produced.
      phase_cur = req_new_frame ? '0 : phase_ff;
      env_cur   = req_new_frame ? '0 : envelope_ff;
      pos_cur   = req_new_frame ? '0 : position_ff;

      // Half length is held within one and the largest supported value.
      half_ext = LIM_W'(half_length_ff);
      if (half_ext == '0) begin
         half_lim = LIM_W'(1);
      end else if (half_ext > MAX_H) begin
         half_lim = MAX_H;
      end else begin
         half_lim = half_ext;
      end
      half_eff   = half_lim[POS_W-1:0];
      twice_half = {half_eff, 1'b0} - (POS_W+1)'(1);
      last_pos   = twice_half[POS_W-1:0];
      // A position at or beyond the end also closes the frame, which covers
      // a half length that was lowered part-way through a burst.
      is_last    = (pos_cur >= last_pos);

      env_up = {1'b0, env_cur} + {1'b0, amp_step_ff};

      if (is_last) begin
         phase_in    = '0;
         envelope_in = '0;
         position_in = '0;
      end else begin
         phase_in = phase_cur + phase_step_ff;
         if (pos_cur < half_eff) begin
            envelope_in = (env_up > {1'b0, ENV_PEAK}) ? ENV_PEAK : env_up[ENV_W-1:0];
         end else begin
            envelope_in = (env_cur > amp_step_ff) ? env_cur - amp_step_ff : '0;
         end
         position_in = pos_cur + POS_W'(1);
      end

      // Table index within the quadrant: floor(phase[29:0] * DEPTH / 2^30).
      idx_prod = PROD_W'(phase_cur[29:0]) * PROD_W'(DEPTH_V);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         envelope_ff <= '0;
         position_ff <= '0;
      end else if (req_accept) begin
         phase_ff    <= phase_in;
         envelope_ff <= envelope_in;
         position_ff <= position_in;
      end
   end

   // ------------------------------------------------------------------------
   // Lookup stage register: quadrant, table index, envelope and frame flag.
   // ------------------------------------------------------------------------
   always_comb begin
      if (req_accept) begin
         a_valid_in = 1'b1;
      end else if (out_load) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_quad_ff <= phase_cur[31:30];
         a_idx_ff  <= idx_prod[PROD_W-1:30];
         a_env_ff  <= env_cur;
         a_last_ff <= is_last;
      end
   end

   // ------------------------------------------------------------------------
   // Sine lookup, envelope scaling, rounding and limiting.
   // ------------------------------------------------------------------------
   logic [IDX_W-1:0]          rom_index;
   logic [SINE_W-1:0]         rom_value;
   logic [ENV_W+SINE_W-1:0]   scaled;
   logic [ENV_W+SINE_W:0]     rounded;
   logic [MAG_W-1:0]          mag;
   logic [MAG_W-1:0]          mag_lim;

   // The second and fourth quadrants walk the table backwards.
   assign rom_index = a_quad_ff[0] ? (DEPTH_V - a_idx_ff) : a_idx_ff;

   spbg_sine_rom #(
      .DEPTH (SINE_TABLE_DEPTH)
   ) u_sine_rom (
      .rom_index (rom_index),
      .rom_value (rom_value)
   );

   always_comb begin
      scaled  = (ENV_W+SINE_W)'(a_env_ff) * (ENV_W+SINE_W)'(rom_value);
      // Adding one half before the shift rounds the magnitude half up.
      rounded = {1'b0, scaled} + (ENV_W+SINE_W+1)'(64'h8000_0000);
      mag     = rounded[ENV_W+SINE_W:32];
      mag_lim = (mag > SAMPLE_LIMIT) ? SAMPLE_LIMIT : mag;
      // The lower half of the turn gives a negative sample.
      if (a_quad_ff[1]) begin
         rsp_sample_in = $signed(SAMPLE_W'(0) - mag_lim[SAMPLE_W-1:0]);
      end else begin
         rsp_sample_in = $signed(mag_lim[SAMPLE_W-1:0]);
      end
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_last_ff   <= a_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample        = rsp_sample_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/spbg_checker.sv
// ----------------------------------------------------------------------------
// Sine ping burst generator port checker
// Watches the top level's ports and flags behaviour the design must not show.
// ----------------------------------------------------------------------------
`default_nettype none

module spbg_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [spbg_pkg::SAMPLE_W-1:0] rsp_sample,
   input wire logic                               rsp_last_of_frame
);
   import spbg_pkg::*;

   localparam logic signed [SAMPLE_W-1:0] POS_LIMIT = 13'sd3000;
   localparam logic signed [SAMPLE_W-1:0] NEG_LIMIT = -13'sd3000;

   // Samples stay within the limit.
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample <= POS_LIMIT) && (rsp_sample >= NEG_LIMIT))
      else $error("response sample outside the limit");

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample)
                                  && $stable(rsp_last_of_frame))
      else $error("stalled response changed");

   // The block never refuses a request while the response side is free.
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request refused with the response side free");

   // Every accepted request is checked to be followed by a valid response.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("no response after an accepted request");

endmodule

bind sine_ping_burst_generator_top spbg_checker u_spbg_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_sample        (rsp_sample),
   .rsp_last_of_frame (rsp_last_of_frame)
);

`default_nettype wire
